// File: rtl/core/tlfc_pkg.sv
// ----------------------------------------------------------------------------
// tlfc_pkg: shared definitions for the text line framer and classifier
// Widths, register indexes, result codes and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfc_pkg;

    // Default line buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Input opcodes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result event kinds
    localparam int EV_W = 3;
    localparam logic [EV_W-1:0] EV_ACK      = 3'd0;
    localparam logic [EV_W-1:0] EV_TEMP     = 3'd1;
    localparam logic [EV_W-1:0] EV_INVALID  = 3'd2;
    localparam logic [EV_W-1:0] EV_TIMEOUT  = 3'd3;
    localparam logic [EV_W-1:0] EV_OVERFLOW = 3'd4;

    // What the latched transaction calls for
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_EVENT,
        ACT_DRAIN
    } t_action;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_item;
        logic apply;
        logic load_event;
        logic rd_start;
        logic load_char;
        logic clear_line;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_action action;
        logic    out_free;
        logic    drain_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/tlfc_ram.sv
// ----------------------------------------------------------------------------
// tlfc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tlfc_datapath.sv
// ----------------------------------------------------------------------------
// tlfc_datapath: line state, value store and result register
// Holds configuration, parses latched bytes and builds result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_datapath #(
    parameter int BUFFER_BYTES = tlfc_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tlfc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [tlfc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic [tlfc_pkg::OP_W-1:0]        i_item_op,
    input  wire logic [7:0]                       i_item_byte,
    input  wire tlfc_pkg::t_dp_cmd                i_cmd,
    output tlfc_pkg::t_dp_stat                    o_stat,
    input  wire logic                             i_m_tready,
    output logic                                  o_m_valid,
    output logic [tlfc_pkg::EV_W-1:0]             o_m_kind,
    output logic                                  o_m_has,
    output logic [7:0]                            o_m_char,
    output logic                                  o_m_last
);

    import tlfc_pkg::*;

    localparam int VALUE_DEPTH = BUFFER_BYTES - 2;
    localparam int LLW         = $clog2(BUFFER_BYTES);
    localparam int VLW         = $clog2(VALUE_DEPTH + 1);
    localparam int AW          = $clog2(VALUE_DEPTH);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_K     = 8'h4B;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_P     = 8'h50;

    // Prefix progress through "ACK" and "TEMP"
    typedef enum logic [3:0] {
        PFX_EMPTY,
        PFX_A,
        PFX_AC,
        PFX_ACK,
        PFX_T,
        PFX_TE,
        PFX_TEM,
        PFX_TEMP,
        PFX_NONE
    } t_pfx;

    function automatic t_pfx f_advance(input t_pfx s, input logic [7:0] c);
        t_pfx r;
        r = PFX_NONE;
        unique case (s)
            PFX_EMPTY: r = (c == CHAR_A) ? PFX_A : ((c == CHAR_T) ? PFX_T : PFX_NONE);
            PFX_A:     r = (c == CHAR_C) ? PFX_AC  : PFX_NONE;
            PFX_AC:    r = (c == CHAR_K) ? PFX_ACK : PFX_NONE;
            PFX_T:     r = (c == CHAR_E) ? PFX_TE  : PFX_NONE;
            PFX_TE:    r = (c == CHAR_M) ? PFX_TEM : PFX_NONE;
            PFX_TEM:   r = (c == CHAR_P) ? PFX_TEMP : PFX_NONE;
            default:   r = PFX_NONE;
        endcase
        return r;
    endfunction

    // Configuration registers
    logic        r_enable;
    logic [7:0]  r_end_char;
    logic [15:0] r_timeout;

    // Latched transaction
    logic [OP_W-1:0] r_op;
    logic [7:0]      r_byte;

    // Line state
    logic [LLW-1:0] r_line_len, n_line_len;
    logic [VLW-1:0] r_vlen, n_vlen;
    logic           r_sep, n_sep;
    t_pfx           r_pfx, n_pfx;
    logic           r_zero, n_zero;
    logic [15:0]    r_age, n_age;

    // Drain index and result register
    logic [VLW-1:0]  r_rd_idx;
    logic            r_out_valid;
    logic [EV_W-1:0] r_out_kind;
    logic            r_out_has;
    logic [7:0]      r_out_char;
    logic            r_out_last;

    logic [7:0]      ram_rdata;
    logic            ram_we;
    logic            out_free;
    logic            drain_last;
    logic [EV_W-1:0] frame_kind;
    logic [EV_W-1:0] ev_kind;
    t_action         action;
    logic            step_clear;
    logic            step_age;
    logic            step_store;
    logic            store_we;
    logic            clear_now;
    logic            has_line;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_end_char <= 8'd10;
            r_timeout  <= 16'd100;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_ENABLE) begin
                r_enable <= i_cfg_wdata[0];
            end
            if (i_cfg_addr == CFG_END_CHAR) begin
                r_end_char <= i_cfg_wdata[7:0];
            end
            if (i_cfg_addr == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_op   <= i_item_op;
            r_byte <= i_item_byte;
        end
    end

    // Frame type from the prefix
    always_comb begin
        if (r_pfx == PFX_ACK) begin
            frame_kind = EV_ACK;
        end else if (r_pfx == PFX_TEMP) begin
            frame_kind = EV_TEMP;
        end else begin
            frame_kind = EV_INVALID;
        end
    end

    assign has_line = (r_line_len != '0);

    // Decode what the latched transaction does
    always_comb begin
        action     = ACT_NONE;
        ev_kind    = EV_INVALID;
        step_clear = 1'b0;
        step_age   = 1'b0;
        step_store = 1'b0;
        if (r_enable) begin
            unique case (r_op)
                OP_TICK: begin
                    if (has_line) begin
                        if (r_age >= r_timeout) begin
                            action     = ACT_EVENT;
                            ev_kind    = EV_TIMEOUT;
                            step_clear = 1'b1;
                        end else begin
                            step_age = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    step_clear = 1'b1;
                end
                OP_BYTE: begin
                    if (r_byte == r_end_char) begin
                        step_clear = 1'b1;
                        if (has_line) begin
                            if (!r_sep) begin
                                action  = ACT_EVENT;
                                ev_kind = EV_INVALID;
                            end else if (r_vlen == '0) begin
                                action  = ACT_EVENT;
                                ev_kind = frame_kind;
                            end else begin
                                action = ACT_DRAIN;
                            end
                        end
                    end else if (r_byte != CHAR_CR) begin
                        if (r_line_len < LLW'(BUFFER_BYTES - 1)) begin
                            step_store = 1'b1;
                        end else begin
                            action     = ACT_EVENT;
                            ev_kind    = EV_OVERFLOW;
                            step_clear = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Next line state
    always_comb begin
        n_line_len = r_line_len;
        n_vlen     = r_vlen;
        n_sep      = r_sep;
        n_pfx      = r_pfx;
        n_zero     = r_zero;
        n_age      = r_age;
        store_we   = 1'b0;
        clear_now  = (i_cfg_we && (i_cfg_addr == CFG_ENABLE)) || i_cmd.clear_line
                     || (i_cmd.apply && step_clear);
        if (clear_now) begin
            n_line_len = '0;
            n_vlen     = '0;
            n_sep      = 1'b0;
            n_pfx      = PFX_EMPTY;
            n_zero     = 1'b0;
            n_age      = '0;
        end else if (i_cmd.apply && step_age) begin
            n_age = r_age + 16'd1;
        end else if (i_cmd.apply && step_store) begin
            n_line_len = r_line_len + LLW'(1);
            if (!r_sep) begin
                if (!r_zero) begin
                    if (r_byte == CHAR_COLON) begin
                        n_sep = 1'b1;
                    end else if (r_byte == CHAR_NUL) begin
                        n_zero = 1'b1;
                    end else begin
                        n_pfx = f_advance(r_pfx, r_byte);
                    end
                end
            end else if (!r_zero) begin
                if (r_byte == CHAR_NUL) begin
                    n_zero = 1'b1;
                end else if (r_vlen < VLW'(VALUE_DEPTH)) begin
                    store_we = 1'b1;
                    n_vlen   = r_vlen + VLW'(1);
                end
            end
        end
    end

    assign ram_we = store_we;

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= '0;
            r_vlen     <= '0;
            r_sep      <= 1'b0;
            r_pfx      <= PFX_EMPTY;
            r_zero     <= 1'b0;
            r_age      <= '0;
        end else begin
            r_line_len <= n_line_len;
            r_vlen     <= n_vlen;
            r_sep      <= n_sep;
            r_pfx      <= n_pfx;
            r_zero     <= n_zero;
            r_age      <= n_age;
        end
    end

    // Value text store
    tlfc_ram #(
        .WIDTH(8),
        .DEPTH(VALUE_DEPTH)
    ) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_vlen[AW-1:0]),
        .i_wdata(r_byte),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    // Advance the drain index
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.load_char) begin
            r_rd_idx <= r_rd_idx + VLW'(1);
        end
    end

    assign drain_last = (r_rd_idx == (r_vlen - VLW'(1)));
    assign out_free   = !r_out_valid || i_m_tready;

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_event || i_cmd.load_char) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_event) begin
            r_out_kind <= ev_kind;
            r_out_has  <= 1'b0;
            r_out_char <= 8'd0;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_char) begin
            r_out_kind <= frame_kind;
            r_out_has  <= 1'b1;
            r_out_char <= ram_rdata;
            r_out_last <= drain_last;
        end
    end

    assign o_stat.action     = action;
    assign o_stat.out_free   = out_free;
    assign o_stat.drain_last = drain_last;

    assign o_m_valid = r_out_valid;
    assign o_m_kind  = r_out_kind;
    assign o_m_has   = r_out_has;
    assign o_m_char  = r_out_char;
    assign o_m_last  = r_out_last;

`ifndef ASSERT_OFF
    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_line_len) <= BUFFER_BYTES - 1)
        else $error("line length beyond buffer");

    a_value_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_vlen) <= 32'(r_line_len))
        else $error("value length exceeds line length");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_event || i_cmd.load_char) |-> out_free)
        else $error("result register loaded while a result is pending");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_line |=> (r_line_len == '0) && (r_vlen == '0))
        else $error("line not cleared after drain");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tlfc_ctrl.sv
// ----------------------------------------------------------------------------
// tlfc_ctrl: sequencing state machine
// Accepts transactions, applies them and drains stored value characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire tlfc_pkg::t_dp_stat  i_stat,
    output tlfc_pkg::t_dp_cmd        o_cmd
);

    import tlfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEND
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    logic   accept;

    assign accept = i_s_tvalid && r_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_EXEC;
                    n_ready          = 1'b0;
                end else begin
                    n_ready = 1'b1;
                end
            end
            S_EXEC: begin
                unique case (i_stat.action)
                    ACT_EVENT: begin
                        if (i_stat.out_free) begin
                            o_cmd.apply      = 1'b1;
                            o_cmd.load_event = 1'b1;
                            n_state          = S_IDLE;
                            n_ready          = 1'b1;
                        end
                    end
                    ACT_DRAIN: begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end
                    default: begin
                        o_cmd.apply = 1'b1;
                        n_state     = S_IDLE;
                        n_ready     = 1'b1;
                    end
                endcase
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.load_char = 1'b1;
                    if (i_stat.drain_last) begin
                        o_cmd.clear_line = 1'b1;
                        n_state          = S_IDLE;
                        n_ready          = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

endmodule

`default_nettype wire

// File: rtl/core/text_line_framer_classifier_core.sv
// ----------------------------------------------------------------------------
// text_line_framer_classifier_core: received-text line framer and classifier
// Gathers bytes into lines, classifies ACK/TEMP frames and streams values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the opcode (byte, tick, clear), tdata the
//   received byte. Master stream: one transaction per result; tuser carries
//   event kind and the has-char flag, tdata the value character, tlast marks
//   the final result caused by one input transaction.
//   Each input transaction is accepted, then applied to update the line state;
//   any single result is loaded into the output register once it is free.
//   An end character that closes a frame with n value characters streams them
//   out in turn: each character costs a registered value RAM read plus a
//   load into the output register.
//   The output register lets an input be accepted while a result waits.
//   A stalled receiver holds the result; the block waits before loading the
//   next one, and input ready stays low until the frame is drained.
//   Reset is synchronous; tready is registered and rises after reset is released.
//   No clearing pass: the value RAM is only read below the stored length.
//   The user writes configuration through the plain write port while idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_framer_classifier_core #(
    parameter int BUFFER_BYTES = tlfc_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tlfc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [tlfc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [7:0]                      i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic [1:0]                      i_s_axis_tuser,  // [1:0] opcode
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [7:0]                           o_m_axis_tdata,  // [7:0] value_char
    output logic [3:0]                           o_m_axis_tuser,  // [2:0] event_kind, [3] has_char
    output logic                                 o_m_axis_tlast
);

    import tlfc_pkg::*;

    t_dp_cmd         cmd;
    t_dp_stat        stat;
    logic [EV_W-1:0] m_kind;
    logic            m_has;

    // Sequencer
    tlfc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_axis_tvalid),
        .o_s_tready(o_s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // Line state and result path
    tlfc_datapath #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_item_op  (i_s_axis_tuser),
        .i_item_byte(i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_kind   (m_kind),
        .o_m_has    (m_has),
        .o_m_char   (o_m_axis_tdata),
        .o_m_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {m_has, m_kind};

endmodule

`default_nettype wire
